// ===== rtl/millisecond_countdown_timer_assert.svh =====
// assertion macros for the millisecond countdown timer checker
// no dependencies; included by the checker file only
`ifndef MILLISECOND_COUNTDOWN_TIMER_ASSERT_SVH
`define MILLISECOND_COUNTDOWN_TIMER_ASSERT_SVH

// clocked assertion, masked while reset is high
`define MCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mct_pkg.sv =====
// shared types and constants for the millisecond countdown timer
// no dependencies; imported by every rtl module
package mct_pkg;

   localparam int ACTION_W   = 3;
   localparam int SEC_W      = 16;
   localparam int DELTA_W    = 32;
   localparam int REM_W      = 26;
   localparam int SINCE_W    = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [REM_W-1:0] MS_PER_SECOND = REM_W'(1000);
   localparam logic [REM_W-1:0] ROUND_UP_ADD  = REM_W'(999);

   // reciprocals, exact for the value ranges used here
   localparam logic [27:0] SEC_RECIP   = 28'd137438954;  // ceil(2^37 / 1000)
   localparam int          SEC_SHIFT   = 37;
   localparam logic [25:0] TENTH_RECIP = 26'd42949673;   // ceil(2^32 / 100)
   localparam int          TENTH_SHIFT = 32;

   localparam logic [REM_W-1:0]   LIMIT_RESET = REM_W'(999000);
   localparam logic [SINCE_W-1:0] DELAY_RESET = SINCE_W'(1000);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SECONDS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EXPIRY_DELAY = CSR_IDX_W'(1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK   = 3'd0,
      ACT_START  = 3'd1,
      ACT_STOP   = 3'd2,
      ACT_TOGGLE = 3'd3,
      ACT_RELOAD = 3'd4,
      ACT_INIT   = 3'd5,
      ACT_ADJUST = 3'd6
   } action_type;

   typedef struct packed {
      action_type                action;
      logic [SEC_W-1:0]          load_seconds;
      logic [DELTA_W-1:0]        offset_ms;
   } item_type;

   typedef struct packed {
      logic                      wr_en;
      logic [CSR_IDX_W-1:0]      index;
      logic [CSR_DATA_W-1:0]     data;
   } csr_wr_type;

   typedef struct packed {
      logic [REM_W-1:0]          remaining;
      logic                      running;
      logic                      late;
   } snap_type;

endpackage

// ===== rtl/millisecond_countdown_timer.sv =====
// top level of the millisecond countdown timer: input register, state stage, result register
// depends on mct_pkg, mct_core and mct_fmt
//
// usage
//  - req_ channel: one word per action (tick, start, stop, toggle, reload, init, adjust),
//    taken when req_valid and req_ready are both high
//  - rsp_ channel: one result word per request word, in order, remaining time in ms,
//    seconds rounded up, tenths, run flag and late-expiry flag
//  - csr_ port: write-only, csr_index 0 is max_seconds, 1 is expiry_delay_ms; write
//    only while nothing is in flight, other indexes are ignored
//  - an accepted word moves from the input register into the state registers, which
//    update as it leaves, and then into the result register with its reciprocal
//    multiplies, which drives rsp_valid
//  - throughput is one word per cycle while the receiver keeps rsp_ready high; the
//    state loop is a single decrement, add and clamp
//  - when the receiver stalls the result register holds and the stages behind it
//    fill; req_ready falls once all three are full and rises as soon as a word leaves
//  - synchronous reset empties the pipe, stops the timer, clears the count and the
//    zero latch and restores max_seconds 999 and expiry_delay_ms 1000
module millisecond_countdown_timer import mct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [SEC_W-1:0]      req_load_seconds,
   input  logic signed [DELTA_W-1:0] req_offset_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [REM_W-1:0]      rsp_left_ms_out,
   output logic [SEC_W-1:0]      rsp_whole_seconds,
   output logic [SEC_W-1:0]      rsp_tenths,
   output logic                  rsp_running_flag,
   output logic                  rsp_late_expiry,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // stage valids: input register, state stage, result register
   logic     in_valid_ff, in_valid_in;
   logic     st_valid_ff, st_valid_in;
   logic     out_valid_ff, out_valid_in;
   item_type item_ff;
   csr_wr_type csr;
   snap_type snap;

   logic out_free, st_ready, st_move, in_move, req_take;

   // a stage may take a word when empty or when its own word moves on
   assign out_free = !out_valid_ff || rsp_ready;
   assign st_ready = !st_valid_ff || out_free;
   assign st_move  = st_valid_ff && out_free;
   assign in_move  = in_valid_ff && st_ready;
   assign req_ready = !in_valid_ff || st_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_move ? 1'b0 : in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end
      st_valid_in  = st_move ? 1'b0 : st_valid_ff;
      if (in_move) begin
         st_valid_in = 1'b1;
      end
      out_valid_in = rsp_ready ? 1'b0 : out_valid_ff;
      if (st_move) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         st_valid_ff  <= st_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input word register, no reset on payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.action       <= action_type'(req_action);
         item_ff.load_seconds <= req_load_seconds;
         item_ff.offset_ms    <= req_offset_ms;
      end
   end

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   // the timer state registers double as the middle stage's data
   mct_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .update (in_move),
      .item   (item_ff),
      .snap   (snap)
   );

   mct_fmt u_fmt (
      .clock            (clock),
      .load             (st_move),
      .snap             (snap),
      .left_ms_ff       (rsp_left_ms_out),
      .whole_seconds_ff (rsp_whole_seconds),
      .tenths_ff        (rsp_tenths),
      .running_ff       (rsp_running_flag),
      .late_ff          (rsp_late_expiry)
   );

   assign rsp_valid = out_valid_ff;

endmodule

// ===== rtl/mct_core.sv =====
// timer state and its update for one word, plus the two settings registers
// depends on mct_pkg
module mct_core import mct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  csr_wr_type csr,
   input  logic       update,
   input  item_type   item,
   output snap_type   snap
);

   logic [REM_W-1:0]   limit_ff;
   logic [SINCE_W-1:0] delay_ff;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               run_ff, run_in;
   logic               zero_ff, zero_in;
   logic [SINCE_W-1:0] since_ff, since_in;

   logic [REM_W-1:0]   limit_in;
   logic [REM_W-1:0]   rem_dec;
   logic [REM_W-1:0]   load_ms;
   logic [33:0]        adj_sum;
   logic [REM_W-1:0]   adj_ms;
   logic               latch_now;

   assign limit_in  = REM_W'(csr.data) * MS_PER_SECOND;
   assign rem_dec   = (rem_ff != '0) ? rem_ff - REM_W'(1) : rem_ff;
   assign load_ms   = REM_W'(item.load_seconds) * MS_PER_SECOND;
   assign latch_now = (rem_ff == '0) && !zero_ff;

   // signed sum, then clamp to zero and to the limit
   assign adj_sum = {8'b0, rem_ff} + {{2{item.offset_ms[DELTA_W-1]}}, item.offset_ms};

   always_comb begin
      if (adj_sum[33]) begin
         adj_ms = '0;
      end else if (adj_sum[32:0] > 33'(limit_ff)) begin
         adj_ms = limit_ff;
      end else begin
         adj_ms = adj_sum[REM_W-1:0];
      end
   end

   always_comb begin
      rem_in   = rem_ff;
      run_in   = run_ff;
      zero_in  = zero_ff;
      since_in = since_ff;
      unique case (item.action)
         ACT_TICK: begin
            if (zero_ff && (since_ff != '1)) begin
               since_in = since_ff + SINCE_W'(1);
            end
            if (run_ff) begin
               rem_in = rem_dec;
               if ((rem_dec == '0) && !zero_ff) begin
                  zero_in  = 1'b1;
                  since_in = '0;
               end
            end
         end
         ACT_START: begin
            run_in = 1'b1;
         end
         ACT_STOP, ACT_TOGGLE: begin
            if (run_ff) begin
               if (latch_now) begin
                  zero_in  = 1'b1;
                  since_in = '0;
               end
               run_in = 1'b0;
            end else if (item.action == ACT_TOGGLE) begin
               run_in = 1'b1;
            end
         end
         ACT_RELOAD, ACT_INIT: begin
            rem_in   = load_ms;
            zero_in  = 1'b0;
            since_in = '0;
            if (item.action == ACT_INIT) begin
               run_in = 1'b0;
            end
         end
         ACT_ADJUST: begin
            if (!run_ff) begin
               rem_in = adj_ms;
               if (adj_ms != '0) begin
                  zero_in  = 1'b0;
                  since_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         delay_ff <= DELAY_RESET;
         rem_ff   <= '0;
         run_ff   <= 1'b0;
         zero_ff  <= 1'b0;
         since_ff <= '0;
      end else begin
         // other indexes are ignored
         if (csr.wr_en) begin
            if (csr.index == CSR_MAX_SECONDS) begin
               limit_ff <= limit_in;
            end else if (csr.index == CSR_EXPIRY_DELAY) begin
               delay_ff <= SINCE_W'(csr.data);
            end
         end
         if (update) begin
            rem_ff   <= rem_in;
            run_ff   <= run_in;
            zero_ff  <= zero_in;
            since_ff <= since_in;
         end
      end
   end

   assign snap.remaining = rem_ff;
   assign snap.running   = run_ff;
   assign snap.late      = (rem_ff == '0) && zero_ff && (since_ff >= delay_ff);

endmodule

// ===== rtl/mct_fmt.sv =====
// result register: seconds rounded up and saturated tenths from the remaining count
// depends on mct_pkg
module mct_fmt import mct_pkg::*; (
   input  logic             clock,
   input  logic             load,
   input  snap_type         snap,
   output logic [REM_W-1:0] left_ms_ff,
   output logic [SEC_W-1:0] whole_seconds_ff,
   output logic [SEC_W-1:0] tenths_ff,
   output logic             running_ff,
   output logic             late_ff
);

   logic [26:0] round_up;
   logic [54:0] sec_prod;
   logic [17:0] sec_quot;
   logic [51:0] tenth_prod;
   logic [19:0] tenth_quot;
   logic [SEC_W-1:0] whole_seconds_in, tenths_in;

   // reciprocal multiplies, no correction step needed
   assign round_up   = 27'(snap.remaining) + 27'(ROUND_UP_ADD);
   assign sec_prod   = 55'(round_up) * 55'(SEC_RECIP);
   assign sec_quot   = sec_prod[54:SEC_SHIFT];
   assign tenth_prod = 52'(snap.remaining) * 52'(TENTH_RECIP);
   assign tenth_quot = tenth_prod[51:TENTH_SHIFT];

   assign whole_seconds_in = sec_quot[SEC_W-1:0];
   assign tenths_in = (tenth_quot[19:16] != '0) ? '1 : tenth_quot[SEC_W-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         left_ms_ff       <= snap.remaining;
         whole_seconds_ff <= whole_seconds_in;
         tenths_ff        <= tenths_in;
         running_ff       <= snap.running;
         late_ff          <= snap.late;
      end
   end

endmodule

// ===== rtl/mct_checker.sv =====
// port-level checks for the millisecond countdown timer, bound to the top level
// depends on mct_pkg and millisecond_countdown_timer_assert.svh
`include "millisecond_countdown_timer_assert.svh"

module mct_checker import mct_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [REM_W-1:0] rsp_left_ms_out,
   input logic [SEC_W-1:0] rsp_whole_seconds,
   input logic [SEC_W-1:0] rsp_tenths,
   input logic             rsp_late_expiry
);

   // a stalled result word stays put
   `MCT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_ms_out), "result word changed while stalled")

   // late expiry only at a count of zero
   `MCT_ASSERT(a_late_at_zero, clock, reset, rsp_valid && rsp_late_expiry |-> rsp_left_ms_out == '0, "late expiry with time remaining")

   // a zero count shows zero in every unit
   `MCT_ASSERT(a_units_zero, clock, reset, rsp_valid && (rsp_left_ms_out == '0) |-> (rsp_whole_seconds == '0) && (rsp_tenths == '0), "units disagree with zero count")

   // reset empties the pipe
   `MCT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind millisecond_countdown_timer mct_checker u_mct_checker (.*);
